// ===== sv/rbsf_pkg.sv =====
`default_nettype none

package rbsf_pkg;

	localparam int RecLen = 7;
	localparam int IdxW   = 4;

	localparam logic [7:0] FlagByte = 8'h7E;
	localparam logic [7:0] EscByte  = 8'h7D;
	localparam logic [7:0] EscXor   = 8'h20;

	localparam logic [IdxW-1:0] IdxFirst = IdxW'(1);
	localparam logic [IdxW-1:0] IdxLast  = IdxW'(RecLen + 1);

	typedef struct packed {
		logic       esc;
		logic [7:0] value;
	} lane_t;

	typedef lane_t [RecLen-1:0] frame_t;

endpackage

`default_nettype wire

// ===== sv/rbsf_lane.sv =====
`default_nettype none

module rbsf_lane (
	input  wire logic [7:0]     rec_byte,
	output rbsf_pkg::lane_t     lane
);

	always_comb begin
		lane.esc   = (rec_byte == rbsf_pkg::FlagByte) || (rec_byte == rbsf_pkg::EscByte);
		lane.value = lane.esc ? (rec_byte ^ rbsf_pkg::EscXor) : rec_byte;
	end

endmodule

`default_nettype wire

// ===== sv/rbsf_serializer.sv =====
`default_nettype none

module rbsf_serializer (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              rec_valid,
	input  wire rbsf_pkg::frame_t  rec_frame,
	output logic                   rec_take,
	output logic                   m_axis_tvalid,
	input  wire logic              m_axis_tready,
	output logic [7:0]             m_axis_tdata,   // line_byte[7:0]
	output logic                   m_axis_tlast    // frame_end
);

	logic                          active_q, active_n;
	logic                          half_q, half_n;
	logic [rbsf_pkg::IdxW-1:0]     idx_q, idx_n;
	rbsf_pkg::frame_t              frame_q, frame_n;
	logic                          m_tvalid_q;
	logic [7:0]                    m_tdata_q;
	logic                          m_tlast_q;

	logic                          out_ok;
	logic                          emit;
	logic [7:0]                    emit_byte;
	logic                          emit_last;
	logic [2:0]                    sel;
	rbsf_pkg::lane_t               cur;

	assign out_ok = !m_tvalid_q || m_axis_tready;
	assign sel    = 3'(idx_q[2:0] - 3'd1);
	assign cur    = frame_q[sel];

	always_comb begin
		active_n  = active_q;
		half_n    = half_q;
		idx_n     = idx_q;
		frame_n   = frame_q;
		emit      = 1'b0;
		emit_byte = rbsf_pkg::FlagByte;
		emit_last = 1'b0;
		rec_take  = 1'b0;
		if (out_ok) begin
			if (active_q) begin
				emit = 1'b1;
				if (idx_q == rbsf_pkg::IdxLast) begin
					emit_byte = rbsf_pkg::FlagByte;
					emit_last = 1'b1;
					active_n  = 1'b0;
				end else if (cur.esc && !half_q) begin
					emit_byte = rbsf_pkg::EscByte;
					half_n    = 1'b1;
				end else begin
					emit_byte = cur.value;
					half_n    = 1'b0;
					idx_n     = idx_q + 1'b1;
				end
			end else if (rec_valid) begin
				// opening delimiter is loaded into the output register in the load cycle
				rec_take  = 1'b1;
				emit      = 1'b1;
				emit_byte = rbsf_pkg::FlagByte;
				active_n  = 1'b1;
				half_n    = 1'b0;
				idx_n     = rbsf_pkg::IdxFirst;
				frame_n   = rec_frame;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q   <= 1'b0;
			half_q     <= 1'b0;
			idx_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			active_q <= active_n;
			half_q   <= half_n;
			idx_q    <= idx_n;
			if (out_ok) begin
				m_tvalid_q <= emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		frame_q <= frame_n;
		if (out_ok) begin
			m_tdata_q <= emit_byte;
			m_tlast_q <= emit_last;
		end
	end

	assign m_axis_tvalid = m_tvalid_q;
	assign m_axis_tdata  = m_tdata_q;
	assign m_axis_tlast  = m_tlast_q;

endmodule

`default_nettype wire

// ===== sv/record_byte_stuffing_framer.sv =====
// Record byte-stuffing framer.
// Input: one record per beat on s_axis (transaction_id, operation, target_address,
// payload_value packed into s_axis_tdata). Output: one frame byte per beat on m_axis,
// tlast set on the closing delimiter.
// Frame: 0x7E, the seven record bytes low byte first with 0x7E/0x7D sent as 0x7D
// followed by the byte XOR 0x20, then a closing 0x7E; 9 to 16 beats per record.
// Seven lanes check the record bytes for escapes in parallel; a one-entry record
// buffer sits in front of the byte serializer, which sends one beat per cycle
// while m_axis_tready does not stall it. An input beat is registered in the
// record buffer; the serializer then registers the opening delimiter into the
// output register. With the next record waiting in the buffer, frames follow
// back to back; a record is accepted while the previous frame is still going out.
// Reset clears the buffer, the serializer and the output register; no frame is
// in flight afterwards. When m_axis_tready is low the output beat holds, the
// serializer waits, and s_axis_tready drops once the record buffer is full.
`default_nettype none

module record_byte_stuffing_framer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [55:0] s_axis_tdata,  // transaction_id[15:0], operation[23:16],
	                                        // target_address[39:24], payload_value[55:40]
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [7:0]       m_axis_tdata,  // line_byte[7:0]
	output logic             m_axis_tlast   // frame_end
);

	rbsf_pkg::frame_t lanes;
	rbsf_pkg::frame_t frame_s1;
	logic             v_s1;
	logic             take;
	logic             in_acc;

	for (genvar i = 0; i < rbsf_pkg::RecLen; i++) begin : g_lane
		rbsf_lane u_lane (
			.rec_byte (s_axis_tdata[8*i +: 8]),
			.lane     (lanes[i])
		);
	end

	assign s_axis_tready = !v_s1 || take;
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_acc) begin
			v_s1 <= 1'b1;
		end else if (take) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			frame_s1 <= lanes;
		end
	end

	rbsf_serializer u_ser (
		.clk           (clk),
		.arst_n        (arst_n),
		.rec_valid     (v_s1),
		.rec_frame     (frame_s1),
		.rec_take      (take),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

`ifndef ASSERT_OFF
	a_last_is_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> m_axis_tdata == rbsf_pkg::FlagByte)
		else $error("frame end beat is not a delimiter");

	a_esc_follow: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && !m_axis_tlast
		&& m_axis_tdata == rbsf_pkg::EscByte
		|=> m_axis_tvalid && (m_axis_tdata == 8'h5E || m_axis_tdata == 8'h5D))
		else $error("escape not followed by stuffed byte");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> v_s1 && !take)
		else $error("input stalled with free buffer");
`endif

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

	typedef struct packed {
		logic signed [15:0] payload_value;
		logic [15:0]        target_address;
		logic [7:0]         operation;
		logic [15:0]        transaction_id;
	} record_t;

	typedef struct packed {
		logic [7:0] line_byte;
		logic       frame_end;
	} line_beat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [55:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [7:0]  m_axis_tdata;
	logic        m_axis_tlast;

	record_t    record_q[$];
	line_beat_t line_q[$];
	int         send_gap = 0;
	int         rx_wait = 0;
	int         records_loaded = 0;
	int         records_sent = 0;
	int         records_total = 0;
	int         beats_seen = 0;
	int         bad_count = 0;

	record_byte_stuffing_framer DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// Expected line bytes for one record: delimiter, stuffed bytes, delimiter.
	task automatic stuff_record(input record_t r);
		logic [7:0] rec_bytes [rbsf_pkg::RecLen];
		rec_bytes[0] = r.transaction_id[7:0];
		rec_bytes[1] = r.transaction_id[15:8];
		rec_bytes[2] = r.operation;
		rec_bytes[3] = r.target_address[7:0];
		rec_bytes[4] = r.target_address[15:8];
		rec_bytes[5] = r.payload_value[7:0];
		rec_bytes[6] = r.payload_value[15:8];
		line_q.push_back('{rbsf_pkg::FlagByte, 1'b0});
		for (int i = 0; i < rbsf_pkg::RecLen; i++) begin
			if (rec_bytes[i] == rbsf_pkg::FlagByte || rec_bytes[i] == rbsf_pkg::EscByte) begin
				line_q.push_back('{rbsf_pkg::EscByte, 1'b0});
				line_q.push_back('{rec_bytes[i] ^ rbsf_pkg::EscXor, 1'b0});
			end else begin
				line_q.push_back('{rec_bytes[i], 1'b0});
			end
		end
		line_q.push_back('{rbsf_pkg::FlagByte, 1'b1});
	endtask

	task automatic flag_error(input string what, input logic [8:0] want, input logic [8:0] got);
		bad_count++;
		if (bad_count <= 10) begin
			$display("%t mismatch %s: expected %h actual %h", $realtime, what, want, got);
		end
	endtask

	function automatic int draw_wait(input bit calm);
		if (calm) begin
			return 0;
		end
		return $urandom_range(0, 18);
	endfunction

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 9))
			0: return rbsf_pkg::FlagByte;
			1: return rbsf_pkg::EscByte;
			2: return rbsf_pkg::FlagByte ^ rbsf_pkg::EscXor;
			3: return rbsf_pkg::EscByte ^ rbsf_pkg::EscXor;
			4: return 8'h00;
			5: return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	task automatic add_record(input logic [15:0] tid, input logic [7:0] op,
		input logic [15:0] adr, input logic [15:0] val);
		record_t r;
		r.transaction_id = tid;
		r.operation      = op;
		r.target_address = adr;
		r.payload_value  = val;
		record_q.push_back(r);
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
			send_gap      <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				stuff_record(record_t'(s_axis_tdata));
				records_sent <= records_sent + 1;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (send_gap > 0) begin
					s_axis_tvalid <= 1'b0;
					send_gap      <= send_gap - 1;
				end else if (record_q.size() > 0) begin
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= record_q.pop_front();
					send_gap      <= draw_wait(((records_loaded / 24) % 3) == 1);
					records_loaded <= records_loaded + 1;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		int w;
		line_beat_t want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			rx_wait       <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (line_q.size() == 0) begin
					flag_error("unexpected beat", 9'h000, {m_axis_tdata, m_axis_tlast});
				end else begin
					want = line_q.pop_front();
					if (m_axis_tdata !== want.line_byte) begin
						flag_error("line_byte", {1'b0, want.line_byte}, {1'b0, m_axis_tdata});
					end
					if (m_axis_tlast !== want.frame_end) begin
						flag_error("frame_end", {8'h00, want.frame_end}, {8'h00, m_axis_tlast});
					end
				end
				beats_seen <= beats_seen + 1;
				w = draw_wait(((beats_seen / 60) % 3) == 2);
				if (w != 0) begin
					m_axis_tready <= 1'b0;
					rx_wait       <= w;
				end
			end else if (!m_axis_tready) begin
				if (rx_wait <= 1) begin
					m_axis_tready <= 1'b1;
					rx_wait       <= 0;
				end else begin
					rx_wait <= rx_wait - 1;
				end
			end
		end
	end

	initial begin
		// extremes, delimiter and escape bytes in every position
		add_record(16'h0000, 8'h00, 16'h0000, 16'h0000);
		add_record(16'hFFFF, 8'hFF, 16'hFFFF, 16'hFFFF);
		add_record(16'h7E7E, 8'h7E, 16'h7E7E, 16'h7E7E);
		add_record(16'h7D7D, 8'h7D, 16'h7D7D, 16'h7D7D);
		add_record(16'h7D7E, 8'h7D, 16'h7E7D, 16'h7D7E);
		add_record(16'h5E5D, 8'h5E, 16'h5D5E, 16'h5E5D);
		add_record(16'h7F7C, 8'h7F, 16'h7C7F, 16'h7F7C);
		add_record(16'h007E, 8'h01, 16'h0203, 16'h0405);
		add_record(16'h7E00, 8'h01, 16'h0203, 16'h0405);
		add_record(16'h0100, 8'h7E, 16'h0203, 16'h0405);
		add_record(16'h0100, 8'h02, 16'h037E, 16'h0405);
		add_record(16'h0100, 8'h02, 16'h7E03, 16'h0405);
		add_record(16'h0100, 8'h02, 16'h0403, 16'h057E);
		add_record(16'h0100, 8'h02, 16'h0403, 16'h7E05);
		add_record(16'h7D00, 8'h01, 16'h0203, 16'h7D05);
		add_record(16'hAAAA, 8'h55, 16'h5555, 16'h7FFF);
		add_record(16'h5555, 8'hAA, 16'hAAAA, 16'h8000);
		add_record(16'h1234, 8'hC3, 16'hBEEF, 16'hFFFF);
		for (int n = 0; n < 152; n++) begin
			if ($urandom_range(0, 3) == 0) begin
				add_record(16'($urandom), 8'($urandom), 16'($urandom), 16'($urandom));
			end else begin
				add_record({pick_byte(), pick_byte()}, pick_byte(),
					{pick_byte(), pick_byte()}, {pick_byte(), pick_byte()});
			end
		end
		records_total = record_q.size();

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		while (records_sent != records_total || line_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (40) @(posedge clk);
		if (bad_count == 0 && line_q.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	initial begin
		#20_000_000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule

// ===== files.f =====
sv/rbsf_pkg.sv
sv/rbsf_lane.sv
sv/rbsf_serializer.sv
sv/record_byte_stuffing_framer.sv
dv/tb_top.sv
